// ----- rtl/spv_pkg.sv -----
// shared constants and types for the sampler voice
package spv_pkg;

	localparam int DEF_ADDR_BITS = 16;
	localparam int DEF_FRAC_BITS = 16;

	localparam int OP_W        = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	typedef logic [OP_W-1:0]        op_t;
	typedef logic [CFG_INDEX_W-1:0] reg_index_t;

	localparam op_t OP_WRITE   = 2'd0;
	localparam op_t OP_TRIGGER = 2'd1;
	localparam op_t OP_STOP    = 2'd2;
	localparam op_t OP_TICK    = 2'd3;

	localparam reg_index_t REG_START  = 3'd0;
	localparam reg_index_t REG_END    = 3'd1;
	localparam reg_index_t REG_LENGTH = 3'd2;
	localparam reg_index_t REG_STEP   = 3'd3;
	localparam reg_index_t REG_GAIN   = 3'd4;
	localparam reg_index_t REG_TRIM   = 3'd5;
	localparam reg_index_t REG_DECAY  = 3'd6;
	localparam reg_index_t REG_TRIM_EN = 3'd7;

	localparam logic [17:0] STEP_RESET  = 18'd65536;
	localparam logic [15:0] GAIN_RESET  = 16'd32768;
	localparam logic [23:0] DECAY_RESET = 24'hFFFFFF;
	localparam logic [24:0] ENV_ONE     = 25'h1000000;

	// operand widths of the shared multiplier
	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

// ----- rtl/sample_playback_voice_top.sv -----
// sampler voice: sample memory, phase accumulator, trim filter, gain and envelope
//
// One sampler voice playing 12-bit offset-binary words from a local sample memory.
// Each input item is one of: memory write, trigger, stop, render tick; each gives
// exactly one result item (audio_out, voice_active). Writes, triggers, stops and
// ticks of an idle or finished voice go straight to the result step. A rendering
// tick first works through the trim, gain, envelope and decay products one after
// another on a single shared 28x26 multiplier, one product per cycle, with a
// filter-state update step after the trim product when the high trim is enabled.
// A finished result sits in the output register, so the next item is taken while
// it waits. The sample memory has no reset; play only addresses that were written.
module sample_playback_voice_top
	import spv_pkg::*;
#(
	parameter int SAMPLE_ADDR_BITS = DEF_ADDR_BITS,
	parameter int PHASE_FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  op_t                    op,
	input  logic [15:0]            mem_address,
	input  logic [11:0]            mem_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [15:0]     audio_out,
	output logic                   voice_active,
	input  logic                   cfg_write_en,
	input  reg_index_t             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int PHASE_W   = PHASE_FRAC_BITS + 18;
	localparam int STEP_SHL  = (PHASE_FRAC_BITS >= 16) ? PHASE_FRAC_BITS - 16 : 0;
	localparam int STEP_SHR  = (PHASE_FRAC_BITS >= 16) ? 0 : 16 - PHASE_FRAC_BITS;
	localparam int MEM_DEPTH = 1 << SAMPLE_ADDR_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TRIM  = 3'd1;
	localparam logic [2:0] ST_LPUPD = 3'd2;
	localparam logic [2:0] ST_GAIN  = 3'd3;
	localparam logic [2:0] ST_ENV   = 3'd4;
	localparam logic [2:0] ST_DEC   = 3'd5;
	localparam logic [2:0] ST_PUSH  = 3'd6;

	// configuration
	logic [15:0] start_index_q;
	logic [16:0] end_index_q;
	logic [16:0] sample_length_q;
	logic [17:0] phase_step_q;
	logic [15:0] voice_gain_q;
	logic [15:0] trim_coef_q;
	logic [23:0] decay_coef_q;
	logic        trim_enable_q;

	// voice state
	logic [2:0]               state_q;
	logic [PHASE_W-1:0]       phase_q;
	logic signed [23:0]       lp_q;
	logic [24:0]              env_q;
	logic                     playing_q;
	logic [16:0]              end_latched_q;
	logic signed [24:0]       shaped_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [15:0]       res_audio_q;
	logic                     out_valid_q;
	logic signed [15:0]       audio_out_q;
	logic                     voice_active_q;

	// sample memory
	logic [11:0] mem [MEM_DEPTH];
	logic [11:0] rd_q;
	logic [SAMPLE_ADDR_BITS-1:0] wr_addr;
	logic [SAMPLE_ADDR_BITS-1:0] rd_addr;

	logic                      in_acc;
	logic                      push_go;
	logic [16:0]               eff_end;
	logic                      at_end;
	logic [PHASE_W-1:0]        step_ext;
	logic [PHASE_W-1:0]        step_scaled;
	logic signed [22:0]        x_val;
	logic signed [24:0]        diff;
	logic signed [24:0]        lp_sum;
	logic signed [22:0]        audio_full;
	logic signed [15:0]        audio_sat;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	assign in_ready     = (state_q == ST_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign push_go      = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign out_valid    = out_valid_q;
	assign audio_out    = audio_out_q;
	assign voice_active = voice_active_q;

	assign wr_addr = SAMPLE_ADDR_BITS'(mem_address);
	assign rd_addr = SAMPLE_ADDR_BITS'(phase_q[PHASE_W-1:PHASE_FRAC_BITS]);

	always_ff @(posedge clk) begin
		if (in_acc && op == OP_WRITE) begin
			mem[wr_addr] <= mem_word;
		end
		rd_q <= mem[rd_addr];
	end

	assign eff_end = (end_index_q > {1'b0, start_index_q} && end_index_q <= sample_length_q)
		? end_index_q : sample_length_q;
	assign at_end  = phase_q >= {1'b0, end_latched_q, {PHASE_FRAC_BITS{1'b0}}};

	assign step_ext    = PHASE_W'(phase_step_q);
	assign step_scaled = (step_ext << STEP_SHL) >> STEP_SHR;

	// offset binary to signed, scaled to q1.22
	assign x_val  = $signed({~rd_q[11], rd_q[10:0], 11'b0});
	assign diff   = 25'(x_val) - 25'(lp_q);
	assign lp_sum = 25'(lp_q) + 25'(prod_q >>> 16);

	assign audio_full = 23'(prod_q >>> 31);
	always_comb begin
		if (audio_full > 23'sd32767) begin
			audio_sat = 16'sh7FFF;
		end else if (audio_full < -23'sd32768) begin
			audio_sat = -16'sh8000;
		end else begin
			audio_sat = audio_full[15:0];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_TRIM: begin
				mul_a = MUL_A_W'($signed({1'b0, trim_coef_q}));
				mul_b = MUL_B_W'(diff);
			end
			ST_GAIN: begin
				mul_a = MUL_A_W'(shaped_q);
				mul_b = MUL_B_W'($signed({1'b0, voice_gain_q}));
			end
			ST_ENV: begin
				mul_a = MUL_A_W'(prod_q >>> 15);
				mul_b = MUL_B_W'($signed({1'b0, env_q}));
			end
			ST_DEC: begin
				mul_a = MUL_A_W'($signed({1'b0, env_q}));
				mul_b = MUL_B_W'($signed({1'b0, decay_coef_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_index_q   <= '0;
			end_index_q     <= '0;
			sample_length_q <= '0;
			phase_step_q    <= STEP_RESET;
			voice_gain_q    <= GAIN_RESET;
			trim_coef_q     <= '0;
			decay_coef_q    <= DECAY_RESET;
			trim_enable_q   <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_START:   start_index_q   <= cfg_data[15:0];
				REG_END:     end_index_q     <= cfg_data[16:0];
				REG_LENGTH:  sample_length_q <= cfg_data[16:0];
				REG_STEP:    phase_step_q    <= cfg_data[17:0];
				REG_GAIN:    voice_gain_q    <= cfg_data[15:0];
				REG_TRIM:    trim_coef_q     <= cfg_data[15:0];
				REG_DECAY:   decay_coef_q    <= cfg_data[23:0];
				REG_TRIM_EN: trim_enable_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= '0;
			lp_q          <= '0;
			env_q         <= '0;
			playing_q     <= 1'b0;
			end_latched_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (push_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_PUSH;
						unique case (op)
							OP_TRIGGER: begin
								phase_q       <= PHASE_W'({start_index_q,
									{PHASE_FRAC_BITS{1'b0}}});
								env_q         <= ENV_ONE;
								lp_q          <= '0;
								end_latched_q <= eff_end;
								playing_q     <= (sample_length_q != '0) &&
									(eff_end > {1'b0, start_index_q});
							end
							OP_STOP: playing_q <= 1'b0;
							OP_TICK: begin
								if (playing_q) begin
									if (at_end) begin
										playing_q <= 1'b0;
									end else begin
										state_q <= ST_TRIM;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_TRIM: begin
					if (trim_enable_q) begin
						state_q <= ST_LPUPD;
					end else begin
						state_q <= ST_GAIN;
					end
				end
				ST_LPUPD: begin
					lp_q    <= lp_sum[23:0];
					state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_ENV;
				ST_ENV:  state_q <= ST_DEC;
				ST_DEC: begin
					env_q   <= mul_p[48:24];
					phase_q <= phase_q + step_scaled;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					// hand over once the output register is free
					if (push_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			res_audio_q <= '0;
		end
		if (state_q == ST_TRIM && !trim_enable_q) begin
			shaped_q <= 25'(x_val);
		end
		if (state_q == ST_LPUPD) begin
			shaped_q <= 25'(x_val) - lp_sum;
		end
		if (state_q == ST_TRIM || state_q == ST_GAIN || state_q == ST_ENV) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_DEC) begin
			res_audio_q <= audio_sat;
		end
		if (push_go) begin
			audio_out_q    <= res_audio_q;
			voice_active_q <= playing_q;
		end
	end

endmodule
